FILE: hw/rtl/elu_pkg.sv
// Shared constants, types and lookup helpers for the ELU activation unit.
`default_nettype none

package elu_pkg;

   localparam int DATA_WIDTH  = 16;
   localparam int FRAC_BITS   = 12;
   localparam int ALPHA_WIDTH = DATA_WIDTH - 1;

   // Internal exponential arithmetic is unsigned Q1.30.
   localparam int IFRAC    = 30;
   localparam int TERMS    = 11;
   localparam int TERM_W   = 4;
   localparam int K_W      = 5;
   localparam int KCOUNT_W = 6;
   localparam int K_LIMIT  = 32;
   localparam int M30_W    = DATA_WIDTH + IFRAC - FRAC_BITS;
   localparam int CMP_W    = (M30_W > 36) ? M30_W : 36;
   localparam int RECIP_W  = 32;

   localparam logic [IFRAC-1:0] LN2_Q30 = 30'd744261118;
   localparam logic [IFRAC:0]   ONE_Q30 = {1'b1, {IFRAC{1'b0}}};

   localparam logic [ALPHA_WIDTH-1:0] ALPHA_RESET = ALPHA_WIDTH'(1 << FRAC_BITS);

   // Configuration port.
   localparam int   CSR_ADDR_W    = 3;
   localparam int   CSR_DATA_W    = 32;
   localparam int   CSR_INDEX_LSB = 2;
   localparam logic REG_ALPHA     = 1'b0;

   // Operation codes.
   localparam logic CMD_FORWARD  = 1'b0;
   localparam logic CMD_BACKWARD = 1'b1;

   // Reciprocals floor((2^32 - 1) / n) for the Horner divisions; entry 0 is unused.
   localparam logic [RECIP_W-1:0] RECIP_TABLE [TERMS+1] = '{
      RECIP_W'(0),
      RECIP_W'(64'hFFFF_FFFF / 64'd1),
      RECIP_W'(64'hFFFF_FFFF / 64'd2),
      RECIP_W'(64'hFFFF_FFFF / 64'd3),
      RECIP_W'(64'hFFFF_FFFF / 64'd4),
      RECIP_W'(64'hFFFF_FFFF / 64'd5),
      RECIP_W'(64'hFFFF_FFFF / 64'd6),
      RECIP_W'(64'hFFFF_FFFF / 64'd7),
      RECIP_W'(64'hFFFF_FFFF / 64'd8),
      RECIP_W'(64'hFFFF_FFFF / 64'd9),
      RECIP_W'(64'hFFFF_FFFF / 64'd10),
      RECIP_W'(64'hFFFF_FFFF / 64'd11)
   };

   typedef logic signed [DATA_WIDTH-1:0] data_type;
   typedef logic [IFRAC-1:0]             frac_type;
   typedef logic [IFRAC:0]               q30_type;

   // Items whose result is already known travel with done set and skip the tail maths.
   typedef struct packed {
      logic                  done;
      logic [DATA_WIDTH-1:0] res;
      logic                  sat;
      logic                  kbig;
      logic [K_W-1:0]        k;
   } side_type;

   typedef struct packed {
      logic     valid;
      side_type side;
      frac_type r;
      q30_type  p;
   } horner_type;

   typedef struct packed {
      logic                  valid;
      logic [DATA_WIDTH-1:0] result;
      logic                  saturated;
   } rsp_type;

   // Multiple k * ln2 in Q.30.
   function automatic logic [CMP_W-1:0] ln2_mult(input logic [KCOUNT_W-1:0] k);
      return CMP_W'(LN2_Q30) * CMP_W'(k);
   endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/elu_csr.sv
// Configuration register block holding the ELU alpha coefficient.
`default_nettype none

module elu_csr (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               csr_psel,
   input  wire                               csr_penable,
   input  wire                               csr_pwrite,
   input  wire  [elu_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  wire  [elu_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [elu_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready,
   output logic [elu_pkg::ALPHA_WIDTH-1:0]   alpha
);
   import elu_pkg::*;

   logic [ALPHA_WIDTH-1:0] alpha_ff;
   logic [ALPHA_WIDTH-1:0] alpha_in;
   logic                   reg_index;
   logic                   write_en;

   assign reg_index  = csr_paddr[CSR_ADDR_W-1:CSR_INDEX_LSB];
   assign write_en   = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;

   always_comb begin
      alpha_in = alpha_ff;
      if (write_en && (reg_index == REG_ALPHA)) begin
         alpha_in = csr_pwdata[ALPHA_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff <= ALPHA_RESET;
      end else begin
         alpha_ff <= alpha_in;
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (reg_index == REG_ALPHA) begin
         csr_prdata = CSR_DATA_W'(alpha_ff);
      end
   end

   assign alpha = alpha_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/elu_front.sv
// Front stages: range reduction of |x| by ln2 and the complete backward-gradient product.
`default_nettype none

module elu_front (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               advance,
   input  wire                               in_valid,
   input  wire                               cmd,
   input  elu_pkg::data_type                 x_value,
   input  elu_pkg::data_type                 grad_in,
   input  elu_pkg::data_type                 fwd_value,
   input  wire  [elu_pkg::ALPHA_WIDTH-1:0]   alpha,
   output elu_pkg::horner_type               out
);
   import elu_pkg::*;

   localparam int DW     = DATA_WIDTH;
   localparam int PROD_W = 2 * DW;
   localparam int BMAG_W = PROD_W - FRAC_BITS;

   // Stage 1: magnitudes.
   logic              v1_ff;
   logic              cmd1_ff;
   logic              xneg1_ff;
   logic [DW-1:0]     pass1_ff;
   logic [M30_W-1:0]  m30_1_ff;
   logic [DW-1:0]     sm1_ff;
   logic [DW-1:0]     gm1_ff;
   logic              pneg1_ff;

   logic [DW-1:0]     x_bits;
   logic [DW-1:0]     g_bits;
   logic [DW-1:0]     f_bits;
   logic              xneg;
   logic [DW-1:0]     xmag;
   logic [DW:0]       s_sum;
   logic [DW:0]       s_abs;
   logic              sneg;
   logic              gneg;
   logic [DW-1:0]     gmag;

   // Stage 2: threshold compares and the gradient product.
   logic              v2_ff;
   logic              cmd2_ff;
   logic              xneg2_ff;
   logic [DW-1:0]     pass2_ff;
   logic [M30_W-1:0]  m30_2_ff;
   logic [K_LIMIT-1:0] therm2_ff;
   logic [K_LIMIT-1:0] therm_in;
   logic [PROD_W-1:0] bprod2_ff;
   logic              pneg2_ff;

   // Stage 3: k, its ln2 multiple, and the packed backward result.
   logic              v3_ff;
   logic [KCOUNT_W-1:0] k3_ff;
   logic [KCOUNT_W-1:0] k_in;
   logic [CMP_W-1:0]  base3_ff;
   logic [M30_W-1:0]  m30_3_ff;
   logic              done3_ff;
   logic [DW-1:0]     res3_ff;
   logic              sat3_ff;

   logic [PROD_W-1:0] bsum;
   logic [BMAG_W-1:0] bmag;
   logic              bneg;
   logic              bsat;
   logic [DW-1:0]     bclip;
   logic [DW-1:0]     bbits;
   logic              done_in;
   logic [DW-1:0]     res_in;
   logic              sat_in;

   // Stage 4: remainder.
   horner_type        out_ff;
   logic [CMP_W-1:0]  r_full;

   assign x_bits = x_value;
   assign g_bits = grad_in;
   assign f_bits = fwd_value;

   always_comb begin
      xneg  = x_bits[DW-1];
      xmag  = xneg ? (DW'(0) - x_bits) : x_bits;
      s_sum = {f_bits[DW-1], f_bits} + {2'b00, alpha};
      sneg  = s_sum[DW];
      s_abs = sneg ? ((DW+1)'(0) - s_sum) : s_sum;
      gneg  = g_bits[DW-1];
      gmag  = gneg ? (DW'(0) - g_bits) : g_bits;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         cmd1_ff  <= cmd;
         xneg1_ff <= xneg;
         pass1_ff <= (cmd == CMD_BACKWARD) ? g_bits : x_bits;
         m30_1_ff <= {xmag, {(IFRAC-FRAC_BITS){1'b0}}};
         sm1_ff   <= s_abs[DW-1:0];
         gm1_ff   <= gmag;
         pneg1_ff <= sneg ^ gneg;
      end
   end

   always_comb begin
      for (int j = 0; j < K_LIMIT; j++) begin
         therm_in[j] = CMP_W'(m30_1_ff) >= ln2_mult(KCOUNT_W'(j + 1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (advance) begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         cmd2_ff   <= cmd1_ff;
         xneg2_ff  <= xneg1_ff;
         pass2_ff  <= pass1_ff;
         m30_2_ff  <= m30_1_ff;
         therm2_ff <= therm_in;
         bprod2_ff <= PROD_W'(sm1_ff) * PROD_W'(gm1_ff);
         pneg2_ff  <= pneg1_ff;
      end
   end

   // The compares form a thermometer code, so k is simply its population count.
   always_comb begin
      k_in  = KCOUNT_W'($countones(therm2_ff));
      bsum  = bprod2_ff + (PROD_W'(1) << (FRAC_BITS - 1));
      bmag  = bsum[PROD_W-1:FRAC_BITS];
      bneg  = pneg2_ff && (bmag != '0);
      if (bneg) begin
         bsat  = bmag > (BMAG_W'(1) << (DW - 1));
         bclip = bsat ? (DW'(1) << (DW - 1)) : bmag[DW-1:0];
         bbits = DW'(0) - bclip;
      end else begin
         bsat  = bmag > ((BMAG_W'(1) << (DW - 1)) - BMAG_W'(1));
         bclip = bsat ? ((DW'(1) << (DW - 1)) - DW'(1)) : bmag[DW-1:0];
         bbits = bclip;
      end
      done_in = !xneg2_ff || (cmd2_ff == CMD_BACKWARD);
      res_in  = xneg2_ff ? bbits : pass2_ff;
      sat_in  = xneg2_ff && (cmd2_ff == CMD_BACKWARD) && bsat;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (advance) begin
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         k3_ff    <= k_in;
         base3_ff <= ln2_mult(k_in);
         m30_3_ff <= m30_2_ff;
         done3_ff <= done_in;
         res3_ff  <= res_in;
         sat3_ff  <= sat_in;
      end
   end

   assign r_full = CMP_W'(m30_3_ff) - base3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_ff.valid <= 1'b0;
      end else if (advance) begin
         out_ff.valid <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff.side.done <= done3_ff;
         out_ff.side.res  <= res3_ff;
         out_ff.side.sat  <= sat3_ff;
         out_ff.side.kbig <= k3_ff[KCOUNT_W-1];
         out_ff.side.k    <= k3_ff[K_W-1:0];
         out_ff.r         <= r_full[IFRAC-1:0];
         out_ff.p         <= ONE_Q30;
      end
   end

   assign out = out_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/elu_horner_step.sv
// One Horner term of the exp(-r) series: multiply, reciprocal divide, correct.
`default_nettype none

module elu_horner_step (
   input  wire                             clock,
   input  wire                             reset,
   input  wire                             advance,
   input  wire  [elu_pkg::TERM_W-1:0]      divisor,
   input  elu_pkg::horner_type             in,
   output elu_pkg::horner_type             out
);
   import elu_pkg::*;

   localparam int PROD_W = 2 * IFRAC + 1;
   localparam int QM_W   = IFRAC + RECIP_W;

   logic              a_valid_ff;
   side_type          a_side_ff;
   frac_type          a_r_ff;
   frac_type          a_t_ff;
   logic [PROD_W-1:0] prod;

   logic              b_valid_ff;
   side_type          b_side_ff;
   frac_type          b_r_ff;
   frac_type          b_t_ff;
   logic [QM_W-1:0]   b_qm_ff;

   frac_type          q0;
   frac_type          rem;
   frac_type          quot;
   horner_type        out_ff;

   assign prod = PROD_W'(in.r) * PROD_W'(in.p);

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         out_ff.valid <= 1'b0;
      end else if (advance) begin
         a_valid_ff   <= in.valid;
         b_valid_ff   <= a_valid_ff;
         out_ff.valid <= b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         a_side_ff <= in.side;
         a_r_ff    <= in.r;
         a_t_ff    <= prod[IFRAC +: IFRAC];
         b_side_ff <= a_side_ff;
         b_r_ff    <= a_r_ff;
         b_t_ff    <= a_t_ff;
         b_qm_ff   <= QM_W'(a_t_ff) * QM_W'(RECIP_TABLE[divisor]);
      end
   end

   // The reciprocal estimate is at most one below the true quotient.
   always_comb begin
      q0   = b_qm_ff[RECIP_W +: IFRAC];
      rem  = b_t_ff - IFRAC'(q0 * IFRAC'(divisor));
      quot = (rem >= IFRAC'(divisor)) ? (q0 + IFRAC'(1)) : q0;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff.side <= b_side_ff;
         out_ff.r    <= b_r_ff;
         out_ff.p    <= ONE_Q30 - {1'b0, quot};
      end
   end

   assign out = out_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/elu_tail.sv
// Tail stages: exp scaling by 2^-k, alpha product, rounding and result selection.
`default_nettype none

module elu_tail (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               advance,
   input  elu_pkg::horner_type               in,
   input  wire  [elu_pkg::ALPHA_WIDTH-1:0]   alpha,
   output elu_pkg::rsp_type                  out
);
   import elu_pkg::*;

   localparam int MAG_W = ALPHA_WIDTH + IFRAC + 1;

   logic             t1_valid_ff;
   side_type         t1_side_ff;
   q30_type          t1_om_ff;
   q30_type          expv;

   logic             t2_valid_ff;
   side_type         t2_side_ff;
   logic [MAG_W-1:0] t2_mag_ff;

   logic [MAG_W-1:0]       rnd;
   logic [ALPHA_WIDTH-1:0] rmag;
   logic [DATA_WIDTH-1:0]  neg_res;
   rsp_type                out_ff;

   // Beyond 31 halvings the exponential has underflowed to zero.
   assign expv = in.side.kbig ? '0 : (in.p >> in.side.k);

   always_ff @(posedge clock) begin
      if (reset) begin
         t1_valid_ff  <= 1'b0;
         t2_valid_ff  <= 1'b0;
         out_ff.valid <= 1'b0;
      end else if (advance) begin
         t1_valid_ff  <= in.valid;
         t2_valid_ff  <= t1_valid_ff;
         out_ff.valid <= t2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         t1_side_ff <= in.side;
         t1_om_ff   <= ONE_Q30 - expv;
         t2_side_ff <= t1_side_ff;
         t2_mag_ff  <= MAG_W'(alpha) * MAG_W'(t1_om_ff);
      end
   end

   always_comb begin
      rnd     = t2_mag_ff + (MAG_W'(1) << (IFRAC - 1));
      rmag    = rnd[IFRAC +: ALPHA_WIDTH];
      neg_res = DATA_WIDTH'(0) - {1'b0, rmag};
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff.result    <= t2_side_ff.done ? t2_side_ff.res : neg_res;
         out_ff.saturated <= t2_side_ff.done && t2_side_ff.sat;
      end
   end

   assign out = out_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/elu_activation_unit_top.sv
// Top level of the ELU activation unit: configuration, pipeline and output skid stage.
`default_nettype none

// Elementwise ELU in signed Q4.12. cmd 0 gives x for x >= 0 and alpha*(exp(x)-1) otherwise;
// cmd 1 gives grad_in for x >= 0 and (fwd_value+alpha)*grad_in, rounded and saturated,
// otherwise. While req_ready is high one transaction is accepted every cycle; each yields
// exactly one result, in order, passing four range-reduction stages, three stages for each
// of the eleven Horner terms of the exponential (multiply, reciprocal multiply,
// correction), three tail stages and the output register. A two-entry output buffer lets
// the unit keep accepting while one result waits; req_ready falls only once both entries
// are full. alpha resets to 1.0 and is written through the APB port at address 0.

module elu_activation_unit_top (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               req_valid,
   output logic                              req_ready,
   input  wire                               req_cmd,
   input  elu_pkg::data_type                 req_x_value,
   input  elu_pkg::data_type                 req_grad_in,
   input  elu_pkg::data_type                 req_fwd_value,
   output logic                              rsp_valid,
   input  wire                               rsp_ready,
   output elu_pkg::data_type                 rsp_result,
   output logic                              rsp_saturated,
   input  wire                               csr_psel,
   input  wire                               csr_penable,
   input  wire                               csr_pwrite,
   input  wire  [elu_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  wire  [elu_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [elu_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready
);
   import elu_pkg::*;

   logic [ALPHA_WIDTH-1:0] alpha;
   logic                   advance;
   logic                   accept;
   horner_type             chain [TERMS+1];
   rsp_type                tail_out;

   logic                   out_v_ff;
   logic                   out_v_in;
   logic [DATA_WIDTH-1:0]  out_res_ff;
   logic [DATA_WIDTH-1:0]  out_res_in;
   logic                   out_sat_ff;
   logic                   out_sat_in;
   logic                   skid_v_ff;
   logic                   skid_v_in;
   logic [DATA_WIDTH-1:0]  skid_res_ff;
   logic [DATA_WIDTH-1:0]  skid_res_in;
   logic                   skid_sat_ff;
   logic                   skid_sat_in;
   logic                   incoming;

   // The whole pipeline moves together and holds only while the skid entry is occupied.
   assign advance   = !skid_v_ff;
   assign req_ready = advance;
   assign accept    = req_valid && req_ready;

   elu_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .alpha       (alpha)
   );

   elu_front u_front (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (accept),
      .cmd       (req_cmd),
      .x_value   (req_x_value),
      .grad_in   (req_grad_in),
      .fwd_value (req_fwd_value),
      .alpha     (alpha),
      .out       (chain[0])
   );

   for (genvar i = 0; i < TERMS; i++) begin : g_term
      elu_horner_step u_step (
         .clock   (clock),
         .reset   (reset),
         .advance (advance),
         .divisor (TERM_W'(TERMS - i)),
         .in      (chain[i]),
         .out     (chain[i+1])
      );
   end

   elu_tail u_tail (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .in      (chain[TERMS]),
      .alpha   (alpha),
      .out     (tail_out)
   );

   assign incoming = tail_out.valid && advance;

   always_comb begin
      out_v_in    = out_v_ff;
      out_res_in  = out_res_ff;
      out_sat_in  = out_sat_ff;
      skid_v_in   = skid_v_ff;
      skid_res_in = skid_res_ff;
      skid_sat_in = skid_sat_ff;
      if (!out_v_ff || rsp_ready) begin
         if (skid_v_ff) begin
            out_v_in   = 1'b1;
            out_res_in = skid_res_ff;
            out_sat_in = skid_sat_ff;
            skid_v_in  = 1'b0;
         end else begin
            out_v_in   = incoming;
            out_res_in = tail_out.result;
            out_sat_in = tail_out.saturated;
         end
      end else if (incoming) begin
         skid_v_in   = 1'b1;
         skid_res_in = tail_out.result;
         skid_sat_in = tail_out.saturated;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else begin
         out_v_ff  <= out_v_in;
         skid_v_ff <= skid_v_in;
      end
   end

   always_ff @(posedge clock) begin
      out_res_ff  <= out_res_in;
      out_sat_ff  <= out_sat_in;
      skid_res_ff <= skid_res_in;
      skid_sat_ff <= skid_sat_in;
   end

   assign rsp_valid     = out_v_ff;
   assign rsp_result    = out_res_ff;
   assign rsp_saturated = out_sat_ff;

`ifndef SYNTHESIS
   // The skid entry is only ever filled behind an occupied output register.
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_v_ff |-> out_v_ff)
      else $error("skid entry holds a transaction while the output register is empty");

   // The skid entry fills only when the output was stalled in the cycle before.
   a_skid_fill_cause: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && $rose(skid_v_ff)) |-> $past(out_v_ff && !rsp_ready))
      else $error("skid entry filled without a stalled output");

   // A buffered transaction moves into the output register once the output is taken.
   a_skid_drains: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && $past(skid_v_ff) && $past(rsp_ready)) |-> (out_v_ff && !skid_v_ff))
      else $error("buffered transaction lost after the output was taken");
`endif

endmodule

`default_nettype wire

FILE: verif/tb_elu_activation_unit_top.sv
// Self-checking testbench for the ELU activation unit: directed, alpha sweep and random traffic.

module tb_elu_activation_unit_top;
   import elu_pkg::*;

   localparam int IDX_W = CSR_ADDR_W - CSR_INDEX_LSB;
   localparam logic [IDX_W-1:0] REG_UNUSED = 1'b1;
   localparam longint unsigned MAG_MAX_POS = (64'd1 << (DATA_WIDTH - 1)) - 1;
   localparam longint unsigned MAG_MAX_NEG = 64'd1 << (DATA_WIDTH - 1);

   typedef struct {
      data_type result;
      logic     saturated;
   } elu_result_type;

   typedef logic [ALPHA_WIDTH-1:0] alpha_bits_type;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   logic                  req_cmd;
   data_type              req_x_value;
   data_type              req_grad_in;
   data_type              req_fwd_value;
   logic                  rsp_valid;
   logic                  rsp_ready;
   data_type              rsp_result;
   logic                  rsp_saturated;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   elu_result_type         pending_results[$];
   logic [ALPHA_WIDTH-1:0] alpha_model;
   int                     mismatch_count = 0;
   int                     items_sent = 0;
   int                     results_checked = 0;
   int                     alpha_settings = 0;
   bit                     req_gaps_on = 1'b1;
   bit                     rsp_stalls_on = 1'b1;
   int                     hold_request = 0;

   elu_activation_unit_top dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_cmd       (req_cmd),
      .req_x_value   (req_x_value),
      .req_grad_in   (req_grad_in),
      .req_fwd_value (req_fwd_value),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_result    (rsp_result),
      .rsp_saturated (rsp_saturated),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .csr_prdata    (csr_prdata),
      .csr_pready    (csr_pready)
   );

   initial clock = 1'b0;
   always #1 clock = ~clock;

   initial begin
      #400000;
      $display("CHECKS FAILED");
      $finish;
   end

   // ELU forward value or gradient for one element, at the unit's fixed-point widths.
   function automatic void elu_predict(input logic cmd, input data_type x, input data_type g,
                                       input data_type f, input logic [ALPHA_WIDTH-1:0] a,
                                       output data_type res, output logic sat);
      longint unsigned one_q30 = 64'd1 << IFRAC;
      longint unsigned ln2 = longint'(LN2_Q30);
      longint unsigned m30, k, r, p, e, mag, sm, gm;
      longint          s;
      logic            neg;
      sat = 1'b0;
      if (x >= 0) begin
         res = (cmd == CMD_BACKWARD) ? g : x;
         return;
      end
      if (cmd == CMD_FORWARD) begin
         // exp(x) by range reduction: |x| = k*ln2 + r, then exp(-r) by Horner and a shift.
         m30 = longint'(-longint'(x)) << (IFRAC - FRAC_BITS);
         k = m30 / ln2;
         r = m30 - k * ln2;
         p = one_q30;
         for (int n = TERMS; n >= 1; n--) begin
            p = one_q30 - ((r * p) >> IFRAC) / longint'(n);
         end
         e = (k > 31) ? 64'd0 : (p >> k);
         mag = (longint'(a) * (one_q30 - e) + (64'd1 << (IFRAC - 1))) >> IFRAC;
         neg = 1'b1;
      end else begin
         s = longint'(f) + longint'(a);
         sm = (s < 0) ? -s : s;
         gm = (g < 0) ? -longint'(g) : longint'(g);
         mag = (sm * gm + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
         neg = ((s < 0) != (g < 0)) && (mag != 0);
      end
      if (neg) begin
         if (mag > MAG_MAX_NEG) begin
            mag = MAG_MAX_NEG;
            sat = 1'b1;
         end
         res = data_type'(-mag);
      end else begin
         if (mag > MAG_MAX_POS) begin
            mag = MAG_MAX_POS;
            sat = 1'b1;
         end
         res = data_type'(mag);
      end
   endfunction

   task automatic log_mismatch(input string what, input longint want_v, input longint got_v);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         $display("Mismatch in %s at %0t: expected %0d, got %0d", what, $time, want_v, got_v);
      end
   endtask

   // Receiver: random stalls, plus a long hold-off whenever one is requested.
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request > 0) begin
            rsp_ready <= 1'b0;
            for (int c = 0; c < hold_request; c++) @(posedge clock);
            hold_request = 0;
         end else if (rsp_stalls_on && $urandom_range(0, 5) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 7) - 1) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin : result_check
      elu_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            log_mismatch("unexpected result", 0, rsp_result);
         end else begin
            want = pending_results.pop_front();
            results_checked++;
            if (rsp_result !== want.result) log_mismatch("result", want.result, rsp_result);
            if (rsp_saturated !== want.saturated) begin
               log_mismatch("saturated", want.saturated, rsp_saturated);
            end
         end
      end
   end

   task automatic send_item(input logic cmd, input data_type x, input data_type g,
                            input data_type f);
      elu_result_type r;
      if (req_gaps_on && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_cmd       <= cmd;
      req_x_value   <= x;
      req_grad_in   <= g;
      req_fwd_value <= f;
      do @(posedge clock); while (!req_ready);
      elu_predict(cmd, x, g, f, alpha_model, r.result, r.saturated);
      pending_results.push_back(r);
      items_sent++;
   endtask

   task automatic send_random(input int count);
      logic     cmd;
      data_type x, g, f;
      for (int i = 0; i < count; i++) begin
         cmd = 1'($urandom_range(0, 1));
         case ($urandom_range(0, 9))
            0, 1, 2, 3: x = data_type'($urandom);
            4, 5, 6:    x = data_type'(-int'($urandom_range(1, 32768)));
            7:          x = data_type'(int'($urandom_range(0, 128)) - 64);
            8: begin
               case ($urandom_range(0, 3))
                  0: x = data_type'(-32768);
                  1: x = data_type'(-1);
                  2: x = '0;
                  default: x = data_type'(32767);
               endcase
            end
            default:    x = data_type'(-int'($urandom_range(0, 6000)));
         endcase
         g = data_type'($urandom);
         // Realistic forward outputs lie in [-alpha, 0]; the rest probe saturation.
         if ($urandom_range(0, 1)) f = data_type'(-int'($urandom_range(0, alpha_model)));
         else f = data_type'($urandom);
         send_item(cmd, x, g, f);
      end
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_access(input logic wr, input logic [IDX_W-1:0] index,
                             input logic [CSR_DATA_W-1:0] value,
                             output logic [CSR_DATA_W-1:0] rdata);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= CSR_ADDR_W'(index) << CSR_INDEX_LSB;
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      if (wr && index == REG_ALPHA) alpha_model = value[ALPHA_WIDTH-1:0];
   endtask

   // Writes alpha with junk in the unused upper bits, pokes the unmapped index, reads back.
   task automatic set_alpha(input logic [ALPHA_WIDTH-1:0] value);
      logic [CSR_DATA_W-1:0] rdata;
      wait_idle();
      csr_access(1'b1, REG_ALPHA, ($urandom & ~CSR_DATA_W'(alpha_bits_type'(-1))) | value,
                 rdata);
      csr_access(1'b1, REG_UNUSED, $urandom, rdata);
      csr_access(1'b0, REG_ALPHA, '0, rdata);
      if (rdata !== CSR_DATA_W'(alpha_model)) log_mismatch("alpha readback", alpha_model, rdata);
      alpha_settings++;
   endtask

   task automatic test_directed();
      logic [CSR_DATA_W-1:0] rdata;
      csr_access(1'b0, REG_ALPHA, '0, rdata);
      if (rdata !== CSR_DATA_W'(alpha_model)) begin
         log_mismatch("alpha after reset", alpha_model, rdata);
      end
      // Forward: zero, positive extreme, tiny and large negatives, near -ln2.
      send_item(CMD_FORWARD, 0, 0, 0);
      send_item(CMD_FORWARD, 32767, -32768, 32767);
      send_item(CMD_FORWARD, 1, 0, 0);
      send_item(CMD_FORWARD, -1, 0, 0);
      send_item(CMD_FORWARD, -2, 0, 0);
      send_item(CMD_FORWARD, -2839, 0, 0);
      send_item(CMD_FORWARD, -4096, 0, 0);
      send_item(CMD_FORWARD, -32767, 0, 0);
      send_item(CMD_FORWARD, -32768, 32767, -32768);
      // Backward pass-through for non-negative x.
      send_item(CMD_BACKWARD, 0, -32768, 12345);
      send_item(CMD_BACKWARD, 32767, 32767, -32768);
      // Backward products: saturation both ways, cancellation to zero and rounding.
      send_item(CMD_BACKWARD, -1, -32768, -32768);
      send_item(CMD_BACKWARD, -1, 32767, 32767);
      send_item(CMD_BACKWARD, -1, -32768, 32767);
      send_item(CMD_BACKWARD, -5, 1234, -4096);
      send_item(CMD_BACKWARD, -5, 1, -4097);
      send_item(CMD_BACKWARD, -3, 4096, -8192);
      send_item(CMD_BACKWARD, -3, 16384, -12288);
      send_item(CMD_BACKWARD, -3, 16384, 4096);
      send_item(CMD_BACKWARD, -7, 2048, -4095);
      send_item(CMD_BACKWARD, -7, 2048, -4097);
      send_item(CMD_BACKWARD, -32768, -32768, 0);
   endtask

   task automatic test_alpha_sweep();
      logic [ALPHA_WIDTH-1:0] settings[6];
      settings = '{alpha_bits_type'(-1), '0, alpha_bits_type'(1),
                   alpha_bits_type'($urandom), alpha_bits_type'(12288), ALPHA_RESET};
      foreach (settings[i]) begin
         set_alpha(settings[i]);
         // With alpha at its extremes the underflow and saturation corners matter most.
         send_item(CMD_FORWARD, -32768, 0, 0);
         send_item(CMD_BACKWARD, -1, -32768, 32767);
         send_random(108);
      end
   endtask

   task automatic test_random_mix();
      for (int blk = 0; blk < 8; blk++) begin
         req_gaps_on   = ($urandom_range(0, 3) != 0);
         rsp_stalls_on = ($urandom_range(0, 3) != 0);
         send_random(100);
      end
      req_gaps_on   = 1'b1;
      rsp_stalls_on = 1'b1;
   endtask

   // The receiver stops for a long while so the pipeline and output buffer fill up.
   task automatic test_backpressure();
      hold_request = 200;
      send_random(80);
   endtask

   task automatic test_drain_pause();
      send_random(30);
      wait_idle();
      send_random(30);
   endtask

   task automatic test_steady_stream();
      req_gaps_on   = 1'b0;
      rsp_stalls_on = 1'b0;
      send_random(120);
   endtask

   initial begin
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_cmd       = CMD_FORWARD;
      req_x_value   = '0;
      req_grad_in   = '0;
      req_fwd_value = '0;
      csr_psel      = 1'b0;
      csr_penable   = 1'b0;
      csr_pwrite    = 1'b0;
      csr_paddr     = '0;
      csr_pwdata    = '0;
      alpha_model   = ALPHA_RESET;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_alpha_sweep();
      test_random_mix();
      test_backpressure();
      test_drain_pause();
      test_steady_stream();

      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);

      $display("Ran %0d transactions, forward and backward, over %0d alpha settings,",
               items_sent, alpha_settings);
      $display("with random gaps, stalls and a long hold-off; %0d results compared, %0d bad.",
               results_checked, mismatch_count);
      if (mismatch_count == 0 && pending_results.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

FILE: elu_activation_unit_top.f
hw/rtl/elu_pkg.sv
hw/rtl/elu_csr.sv
hw/rtl/elu_front.sv
hw/rtl/elu_horner_step.sv
hw/rtl/elu_tail.sv
hw/rtl/elu_activation_unit_top.sv
verif/tb_elu_activation_unit_top.sv
